// ===== hw/rtl/ewg_pkg.sv =====
// Shared types and constants for the elliptical waypoint generator.
`default_nettype none
package ewg_pkg;

  localparam int AXIS_W     = 16;
  localparam int STEP_W     = 14;
  localparam int POS_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MAG_W      = 17;
  localparam int SINE_W     = 18;
  localparam int ROM_W      = 16;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SEMI_AXIS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEMI_AXIS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 2'd2;

  localparam logic [AXIS_W-1:0] SEMI_AXIS_RESET  = 16'd4096;
  localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 14'd104;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] ROUND_Q15   = 64'd16384;
  localparam logic [63:0] DENOM_0     = 64'd156;
  localparam logic [63:0] DENOM_1     = 64'd110;
  localparam logic [63:0] DENOM_2     = 64'd72;
  localparam logic [63:0] DENOM_3     = 64'd42;
  localparam logic [63:0] DENOM_4     = 64'd20;
  localparam logic [63:0] DENOM_5     = 64'd6;

  typedef struct packed {
    logic start_accepted;
    logic waypoint_valid;
    logic lap_finished;
  } ewg_flags_t;

  localparam int FLAGS_W = $bits(ewg_flags_t);

endpackage
`default_nettype wire

// ===== hw/rtl/ewg_in_if.sv =====
// Command channel interface: valid, ready and the command payload.
`default_nettype none
interface ewg_in_if;
  logic valid;
  logic ready;
  logic command;
  logic clockwise;

  modport source (output valid, output command, output clockwise, input ready);
  modport sink (input valid, input command, input clockwise, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ewg_out_if.sv =====
// Result channel interface: valid, ready and the waypoint payload.
`default_nettype none
interface ewg_out_if;
  logic               valid;
  logic               ready;
  logic               start_accepted;
  logic               waypoint_valid;
  logic               lap_finished;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;

  modport source (output valid, output start_accepted, output waypoint_valid,
                  output lap_finished, output pos_x, output pos_y, input ready);
  modport sink (input valid, input start_accepted, input waypoint_valid,
                input lap_finished, input pos_x, input pos_y, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ewg_front.sv =====
// Front end: accepts commands, tracks the lap state and classifies each result.
`default_nettype none
module ewg_front #(
  parameter int PHASE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_command,
  input  wire logic                          in_clockwise,
  output      logic                          in_ready,
  input  wire logic [ewg_pkg::STEP_W-1:0]    phase_step,
  input  wire logic                          q_full,
  output      logic                          q_push,
  output      ewg_pkg::ewg_flags_t           q_flags,
  output      logic [PHASE_BITS-1:0]         q_phase
);

  localparam int OFF_W = ((PHASE_BITS > ewg_pkg::STEP_W) ? PHASE_BITS : ewg_pkg::STEP_W) + 2;
  localparam logic signed [OFF_W-1:0] FULL_POS = OFF_W'(1) <<< PHASE_BITS;
  localparam logic signed [OFF_W-1:0] FULL_NEG = -FULL_POS;
  localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

  logic                    moving_r, moving_nxt;
  logic                    cw_r, cw_nxt;
  logic signed [OFF_W-1:0] off_r, off_nxt;
  logic signed [OFF_W-1:0] step_ext;
  logic signed [OFF_W-1:0] off_adv;
  logic                    done;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign step_ext = signed'(OFF_W'(phase_step));
  assign off_adv  = cw_r ? (off_r - step_ext) : (off_r + step_ext);
  assign done     = (off_adv >= FULL_POS) || (off_adv <= FULL_NEG);
  assign q_phase  = off_adv[PHASE_BITS-1:0] + QUARTER;

  always_comb begin
    moving_nxt = moving_r;
    cw_nxt     = cw_r;
    off_nxt    = off_r;
    q_flags    = '0;
    if (in_command == ewg_pkg::CMD_START) begin
      if (!moving_r) begin
        moving_nxt             = 1'b1;
        cw_nxt                 = in_clockwise;
        off_nxt                = '0;
        q_flags.start_accepted = 1'b1;
      end
    end else if (moving_r) begin
      off_nxt = off_adv;
      if (done) begin
        moving_nxt           = 1'b0;
        q_flags.lap_finished = 1'b1;
      end else begin
        q_flags.waypoint_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r <= 1'b0;
      cw_r     <= 1'b0;
      off_r    <= '0;
    end else if (q_push) begin
      moving_r <= moving_nxt;
      cw_r     <= cw_nxt;
      off_r    <= off_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ewg_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
`default_nettype none
module ewg_queue #(
  parameter int WIDTH = 19
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] pop_data,
  output      logic             full,
  output      logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ewg_back.sv =====
// Back end: sine and cosine lookup, axis scaling with rounding and saturation.
`default_nettype none
module ewg_back #(
  parameter int PHASE_BITS       = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               q_empty,
  input  wire ewg_pkg::ewg_flags_t                q_flags,
  input  wire logic [PHASE_BITS-1:0]              q_phase,
  output      logic                               q_pop,
  input  wire logic signed [ewg_pkg::AXIS_W-1:0]  semi_axis_x,
  input  wire logic signed [ewg_pkg::AXIS_W-1:0]  semi_axis_y,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      ewg_pkg::ewg_flags_t                out_flags,
  output      logic signed [ewg_pkg::POS_W-1:0]   out_pos_x,
  output      logic signed [ewg_pkg::POS_W-1:0]   out_pos_y
);

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int QBITS  = PHASE_BITS - 2;
  localparam int PROD_W = QBITS + IDX_W;
  localparam int MUL_W  = ewg_pkg::AXIS_W + ewg_pkg::SINE_W;
  localparam logic [PROD_W-1:0] DEPTH_V = PROD_W'(SINE_TABLE_DEPTH);
  localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << QBITS;
  localparam logic [QBITS:0] QUARTER_R = (QBITS + 1)'(1) << QBITS;
  localparam logic [ewg_pkg::MAG_W-1:0] MAG_ONE = ewg_pkg::MAG_W'(1) << 15;
  localparam logic signed [MUL_W-1:0] ROUND_C = MUL_W'(ewg_pkg::ROUND_Q15);
  localparam logic signed [MUL_W-16:0] POS_MAX = (MUL_W - 15)'(32767);
  localparam logic signed [MUL_W-16:0] POS_MIN = -(MUL_W - 15)'(32768);

  logic [ewg_pkg::ROM_W-1:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam logic [63:0] X  = (ewg_pkg::HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
    localparam logic [63:0] X2 = (X * X) >> 30;
    localparam logic [63:0] T1 = ewg_pkg::Q30_ONE
                                 - (((X2 * ewg_pkg::Q30_ONE) >> 30) / ewg_pkg::DENOM_0);
    localparam logic [63:0] T2 = ewg_pkg::Q30_ONE - (((X2 * T1) >> 30) / ewg_pkg::DENOM_1);
    localparam logic [63:0] T3 = ewg_pkg::Q30_ONE - (((X2 * T2) >> 30) / ewg_pkg::DENOM_2);
    localparam logic [63:0] T4 = ewg_pkg::Q30_ONE - (((X2 * T3) >> 30) / ewg_pkg::DENOM_3);
    localparam logic [63:0] T5 = ewg_pkg::Q30_ONE - (((X2 * T4) >> 30) / ewg_pkg::DENOM_4);
    localparam logic [63:0] T6 = ewg_pkg::Q30_ONE - (((X2 * T5) >> 30) / ewg_pkg::DENOM_5);
    localparam logic [63:0] S  = (X * T6) >> 30;
    localparam logic [63:0] E  = (S + ewg_pkg::ROUND_Q15) >> 15;
    assign sine_rom[i] = E[ewg_pkg::ROM_W-1:0];
  end

  // Lane 0 is the cosine (phase plus a quarter turn), lane 1 the sine.
  logic signed [ewg_pkg::SINE_W-1:0] lane_val [2];
  logic                              s1_valid_r;
  ewg_pkg::ewg_flags_t               s1_flags_r;
  logic signed [ewg_pkg::SINE_W-1:0] s1_val_r [2];
  logic                              s1_en;
  logic                              s2_en;
  logic signed [MUL_W-1:0]           prod [2];
  logic signed [MUL_W-1:0]           rnd [2];
  logic signed [ewg_pkg::POS_W-1:0]  pos [2];
  logic signed [ewg_pkg::AXIS_W-1:0] axis [2];

  assign axis[0] = semi_axis_x;
  assign axis[1] = semi_axis_y;

  always_comb begin
    logic [PHASE_BITS-1:0]      ph;
    logic [1:0]                 quad;
    logic [QBITS:0]             rpos;
    logic [PROD_W-1:0]          scaled;
    logic [IDX_W-1:0]           idx;
    logic [ewg_pkg::MAG_W-1:0]  mag;
    for (int k = 0; k < 2; k++) begin
      ph     = (k == 0) ? (q_phase + QUARTER) : q_phase;
      quad   = ph[PHASE_BITS-1 -: 2];
      rpos   = {1'b0, ph[QBITS-1:0]};
      if (quad[0]) begin
        rpos = QUARTER_R - rpos;
      end
      scaled = PROD_W'(rpos[QBITS-1:0]) * DEPTH_V;
      idx    = scaled[QBITS +: IDX_W];
      mag    = rpos[QBITS] ? MAG_ONE : {1'b0, sine_rom[idx]};
      lane_val[k] = quad[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      prod[k] = MUL_W'(axis[k]) * MUL_W'(s1_val_r[k]);
      rnd[k]  = prod[k] + ROUND_C;
      if (signed'(rnd[k][MUL_W-1:15]) > POS_MAX) begin
        pos[k] = 16'sd32767;
      end else if (signed'(rnd[k][MUL_W-1:15]) < POS_MIN) begin
        pos[k] = -16'sd32768;
      end else begin
        pos[k] = rnd[k][ewg_pkg::POS_W+14:15];
      end
    end
  end

  assign s2_en = !out_valid || out_ready;
  assign s1_en = !s1_valid_r || s2_en;
  assign q_pop = s1_en && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_r <= !q_empty;
      end
      if (s2_en) begin
        out_valid <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_flags_r  <= q_flags;
      s1_val_r[0] <= lane_val[0];
      s1_val_r[1] <= lane_val[1];
    end
    if (s2_en) begin
      out_flags <= s1_flags_r;
      out_pos_x <= s1_flags_r.waypoint_valid ? pos[0] : '0;
      out_pos_y <= s1_flags_r.waypoint_valid ? pos[1] : '0;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/elliptical_waypoint_generator.sv =====
// Top level of the elliptical waypoint generator: configuration and channel wiring.
//
//   Channel   Direction  Transfer condition          Payload
//   in_ch     sink       in_ch.valid & in_ch.ready   command, clockwise
//   out_ch    source     out_ch.valid & out_ch.ready start_accepted, waypoint_valid,
//                                                    lap_finished, pos_x, pos_y
//   cfg_*     write      cfg_we                      cfg_index, cfg_data
//
// One command is taken per cycle while the queue is not full; in_ch.ready is low otherwise.
// The transfer edge writes the queue, then come the table lookup stage and the multiply stage.
// Reset is synchronous and clears the lap state, the queue and the pipeline valids.
// A stalled result port fills the two-entry queue, after which in_ch.ready drops.
`default_nettype none
module elliptical_waypoint_generator #(
  parameter int PHASE_BITS       = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  ewg_in_if.sink                                   in_ch,
  ewg_out_if.source                                out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [ewg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ewg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int Q_W = ewg_pkg::FLAGS_W + PHASE_BITS;

  logic signed [ewg_pkg::AXIS_W-1:0] semi_x_r;
  logic signed [ewg_pkg::AXIS_W-1:0] semi_y_r;
  logic [ewg_pkg::STEP_W-1:0]        step_r;

  logic                       q_push;
  logic                       q_pop;
  logic                       q_full;
  logic                       q_empty;
  ewg_pkg::ewg_flags_t        f_flags;
  logic [PHASE_BITS-1:0]      f_phase;
  logic [Q_W-1:0]             q_rd;
  ewg_pkg::ewg_flags_t        b_flags;
  ewg_pkg::ewg_flags_t        o_flags;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      semi_x_r <= ewg_pkg::SEMI_AXIS_RESET;
      semi_y_r <= ewg_pkg::SEMI_AXIS_RESET;
      step_r   <= ewg_pkg::PHASE_STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ewg_pkg::REG_SEMI_AXIS_X: semi_x_r <= cfg_data;
        ewg_pkg::REG_SEMI_AXIS_Y: semi_y_r <= cfg_data;
        ewg_pkg::REG_PHASE_STEP:  step_r   <= cfg_data[ewg_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  ewg_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_command   (in_ch.command),
    .in_clockwise (in_ch.clockwise),
    .in_ready     (in_ch.ready),
    .phase_step   (step_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_flags      (f_flags),
    .q_phase      (f_phase)
  );

  ewg_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_flags, f_phase}),
    .pop       (q_pop),
    .pop_data  (q_rd),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign b_flags = q_rd[Q_W-1 -: ewg_pkg::FLAGS_W];

  ewg_back #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_flags     (b_flags),
    .q_phase     (q_rd[PHASE_BITS-1:0]),
    .q_pop       (q_pop),
    .semi_axis_x (semi_x_r),
    .semi_axis_y (semi_y_r),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_flags   (o_flags),
    .out_pos_x   (out_ch.pos_x),
    .out_pos_y   (out_ch.pos_y)
  );

  assign out_ch.start_accepted = o_flags.start_accepted;
  assign out_ch.waypoint_valid = o_flags.waypoint_valid;
  assign out_ch.lap_finished   = o_flags.lap_finished;

endmodule
`default_nettype wire
